### sv/bqri_pkg.sv
// shared types and constants of the bounded record queue
package bqri_pkg;

	localparam int QR_CAPACITY = 8;
	localparam int NAME_W      = 64;
	localparam int GENDER_W    = 8;
	localparam int AGE_W       = 8;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_READ   = 2'd3
	} bqri_op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADIDX = 2'd3
	} bqri_status_t;

	typedef struct packed {
		logic [NAME_W-1:0]   name;
		logic [GENDER_W-1:0] gender;
		logic [AGE_W-1:0]    age;
	} bqri_rec_t;

	// per-cell update controls
	typedef struct packed {
		logic load;   // take the pushed record
		logic shift;  // take the neighbor's record
	} bqri_cell_ctl_t;

endpackage

### sv/bqri_cell.sv
// one queue slot: holds a record, loads a push or takes its upper neighbor's record
module bqri_cell (
	input  logic                clk,
	input  bqri_pkg::bqri_cell_ctl_t ctl,
	input  bqri_pkg::bqri_rec_t push_rec,
	input  bqri_pkg::bqri_rec_t next_rec,
	output bqri_pkg::bqri_rec_t rec
);
	import bqri_pkg::*;

	bqri_rec_t rec_q;

	// contents undefined until written, so no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rec_q <= push_rec;
		end else if (ctl.shift) begin
			rec_q <= next_rec;
		end
	end

	assign rec = rec_q;

endmodule

### sv/bounded_queue_remove_at_index.sv
// top level of the bounded record queue with removal at an index
//
// a fifo of up to CAPACITY records (64-bit name, gender byte, age byte) kept
// in a row of cells, slot 0 being the head. every input transaction carries
// one operation in s_tuser: push at the tail, pop the head, remove at a
// position (later entries move down one slot) or read at a position. every
// input transaction gives exactly one output transaction with a status in
// m_tuser and the record concerned plus the count held afterwards in m_tdata.
// refused operations leave the queue untouched and return a zero record; a
// successful push echoes the pushed record. remove and read on an empty queue
// report empty whatever the position. all cells update in the same cycle, and
// one transaction per cycle is taken as long as the output side keeps up; the
// single output register lets a new transaction in while the previous result
// is being taken. output valid rises in the cycle after input acceptance.
module bounded_queue_remove_at_index #(
	parameter  int CAPACITY = bqri_pkg::QR_CAPACITY,
	localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNT_W    = $clog2(CAPACITY + 1),
	localparam int IN_W     = ((POS_W + 80 + 7) / 8) * 8,
	localparam int OUT_W    = ((80 + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // position, name_chars, gender_code, age_years, zero fill
	input  logic [1:0]       s_tuser,  // mode
	// output stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // out_name, out_gender, out_age, entry_count, zero fill
	output logic [1:0]       m_tuser   // status
);
	import bqri_pkg::*;

	localparam int NAME_LO   = POS_W;
	localparam int GENDER_LO = NAME_LO + NAME_W;
	localparam int AGE_LO    = GENDER_LO + GENDER_W;

	// input field unpacking
	bqri_op_t         op;
	logic [POS_W-1:0] pos;
	bqri_rec_t        push_rec;
	logic             accept;

	assign op              = bqri_op_t'(s_tuser);
	assign pos             = s_tdata[POS_W-1:0];
	assign push_rec.name   = s_tdata[GENDER_LO-1:NAME_LO];
	assign push_rec.gender = s_tdata[AGE_LO-1:GENDER_LO];
	assign push_rec.age    = s_tdata[AGE_LO+AGE_W-1:AGE_LO];

	// the output register frees up when its result is taken
	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_ext;

	assign pos_ext = CNT_W'(pos);

	// operation decode and checks
	bqri_status_t     status;
	logic [POS_W-1:0] sel_idx;
	logic             push_ok;
	logic             read_ok;
	logic             remove_ok;

	always_comb begin
		status    = ST_OK;
		sel_idx   = '0;
		push_ok   = 1'b0;
		read_ok   = 1'b0;
		remove_ok = 1'b0;
		unique case (op)
			OP_PUSH: begin
				if (count_q == CNT_W'(CAPACITY)) begin
					status = ST_FULL;
				end else begin
					push_ok = 1'b1;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					read_ok   = 1'b1;
					remove_ok = 1'b1;
				end
			end
			OP_REMOVE, OP_READ: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (pos_ext >= count_q) begin
					status = ST_BADIDX;
				end else begin
					sel_idx   = pos;
					read_ok   = 1'b1;
					remove_ok = (op == OP_REMOVE);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// chain of cells, slot 0 at the head
	bqri_rec_t      cell_rec [CAPACITY];
	bqri_rec_t      cell_next[CAPACITY];
	bqri_cell_ctl_t cell_ctl [CAPACITY];

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		// last slot has no upper neighbor: it keeps its own record on a shift
		if (k == CAPACITY - 1) begin : g_last
			assign cell_next[k] = cell_rec[k];
		end else begin : g_mid
			assign cell_next[k] = cell_rec[k+1];
		end

		// push lands in the first free slot; removal moves every slot at or
		// above the removed one down by one
		assign cell_ctl[k].load  = accept && push_ok && (count_q == CNT_W'(k));
		assign cell_ctl[k].shift = accept && remove_ok && (CNT_W'(k) >= CNT_W'(sel_idx));

		bqri_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[k]),
			.push_rec (push_rec),
			.next_rec (cell_next[k]),
			.rec      (cell_rec[k])
		);
	end

	// pick the addressed slot
	bqri_rec_t sel_rec;

	always_comb begin
		sel_rec = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (sel_idx == POS_W'(k)) begin
				sel_rec = cell_rec[k];
			end
		end
	end

	bqri_rec_t        res_rec;
	logic [CNT_W-1:0] next_count;

	always_comb begin
		priority if (push_ok) begin
			res_rec = push_rec;
		end else if (read_ok) begin
			res_rec = sel_rec;
		end else begin
			res_rec = '0;
		end
	end

	always_comb begin
		priority if (push_ok) begin
			next_count = count_q + CNT_W'(1);
		end else if (remove_ok) begin
			next_count = count_q - CNT_W'(1);
		end else begin
			next_count = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= next_count;
		end
	end

	// output register
	logic             out_valid_q;
	bqri_status_t     out_status_q;
	bqri_rec_t        out_rec_q;
	logic [CNT_W-1:0] out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status;
			out_rec_q    <= res_rec;
			out_count_q  <= next_count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = OUT_W'({out_count_q, out_rec_q.age, out_rec_q.gender, out_rec_q.name});

endmodule
